>>> hdl/dtlq_pkg.sv
`default_nettype none

package dtlq_pkg;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned SizeW    = 20;
  localparam int unsigned CapW     = 16;
  localparam int unsigned PropW    = 24;
  localparam int unsigned BufW     = 32;
  localparam int unsigned BacklogW = 33;
  localparam int unsigned DrainW   = TimeW + CapW;
  localparam int unsigned DepartW  = 34;
  localparam int unsigned QuoW     = 32;
  localparam int unsigned StepCntW = $clog2(QuoW);
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned AddrW    = 4;
  localparam int unsigned ApbDataW = 32;

  localparam logic [1:0] RegCapacity    = 2'd0;
  localparam logic [1:0] RegPropagation = 2'd1;
  localparam logic [1:0] RegBuffer      = 2'd2;

  localparam logic [CapW-1:0]  CapReset  = CapW'(1);
  localparam logic [PropW-1:0] PropReset = '0;
  localparam logic [BufW-1:0]  BufReset  = '0;

  typedef struct packed {
    logic [CapW-1:0]  cap_eff;
    logic [PropW-1:0] prop;
    logic [BufW-1:0]  buf_bits;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MUL   = 6'b000010,
    ST_DRAIN = 6'b000100,
    ST_CHECK = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

endpackage

`default_nettype wire

>>> hdl/drop_tail_link_queue_timer_core.sv
// Drop-tail link queue timer.
// Input stream: one transaction per packet arrival; s_axis_tdata carries
// arrival_time, packet_bits and from_end. Output stream: one transaction per
// arrival with accepted, depart_time and to_end. The APB port sets link
// capacity, propagation delay and buffer size; write it only while idle.
// Each packet is handled alone: s_axis_tready is high only while the
// sequencer is idle. An admitted packet runs multiply, drain, admission
// check, then a 32-step restoring divide (one quotient bit per cycle in the
// divider); a dropped packet skips the divide and goes from the admission
// check straight to the done state, where its result is handed on.
// The result sits in an output register; the next packet is accepted while
// it waits, and that packet's result holds in the sequencer until the
// receiver takes the pending one. Reset clears backlog and last arrival time
// and loads capacity 1, propagation 0 and buffer 0.
`default_nettype none

module drop_tail_link_queue_timer_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // [31:0] arrival_time, [51:32] packet_bits, [52] from_end, [55:53] zero
  input  wire logic [dtlq_pkg::InDataW-1:0]        s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // [0] accepted, [34:1] depart_time, [35] to_end, [39:36] zero
  output logic      [dtlq_pkg::OutDataW-1:0]       m_axis_tdata,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [dtlq_pkg::AddrW-1:0]          paddr,
  input  wire logic [dtlq_pkg::ApbDataW-1:0]       pwdata,
  output logic      [dtlq_pkg::ApbDataW-1:0]       prdata,
  output logic                                     pready
);

  dtlq_pkg::cfg_t      cfg;
  dtlq_pkg::div_stat_t div_stat;
  dtlq_pkg::state_e    state_q, state_d;

  logic [dtlq_pkg::TimeW-1:0]    now_q, last_q, elapsed_q;
  logic [dtlq_pkg::SizeW-1:0]    size_q;
  logic                          from_q;
  logic [dtlq_pkg::DrainW-1:0]   drain_q, product;
  logic [dtlq_pkg::BacklogW-1:0] backlog_q, drained, total;
  logic [dtlq_pkg::TimeW:0]      base_q;
  logic [dtlq_pkg::DepartW-1:0]  depart_q;
  logic                          acc_q;
  logic                          admit, div_start, in_hs, out_free;
  logic [dtlq_pkg::QuoW-1:0]     quotient;
  logic [dtlq_pkg::TimeW-1:0]    s_now;
  logic                          m_valid_q;
  logic [dtlq_pkg::OutDataW-1:0] m_data_q;

  dtlq_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dtlq_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (total[dtlq_pkg::QuoW-1:0]),
    .divisor_i  (cfg.cap_eff),
    .quotient_o (quotient),
    .stat_o     (div_stat)
  );

  assign s_now         = s_axis_tdata[dtlq_pkg::TimeW-1:0];
  assign s_axis_tready = (state_q == dtlq_pkg::ST_IDLE);
  assign in_hs         = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  assign product = elapsed_q * cfg.cap_eff;
  assign drained = (drain_q >= {15'b0, backlog_q}) ? '0 :
                   backlog_q - drain_q[dtlq_pkg::BacklogW-1:0];
  assign total   = backlog_q + {13'b0, size_q};
  assign admit   = total < {1'b0, cfg.buf_bits};
  assign div_start = (state_q == dtlq_pkg::ST_CHECK) && admit;

  always_comb begin
    state_d = state_q;
    case (state_q)
      dtlq_pkg::ST_IDLE:  if (in_hs) state_d = dtlq_pkg::ST_MUL;
      dtlq_pkg::ST_MUL:   state_d = dtlq_pkg::ST_DRAIN;
      dtlq_pkg::ST_DRAIN: state_d = dtlq_pkg::ST_CHECK;
      dtlq_pkg::ST_CHECK: state_d = admit ? dtlq_pkg::ST_DIV : dtlq_pkg::ST_DONE;
      dtlq_pkg::ST_DIV:   if (div_stat.done) state_d = dtlq_pkg::ST_DONE;
      dtlq_pkg::ST_DONE:  if (out_free) state_d = dtlq_pkg::ST_IDLE;
      default:            state_d = dtlq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dtlq_pkg::ST_IDLE;
      backlog_q <= '0;
      last_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_hs) begin
        last_q <= s_now;
      end
      if (state_q == dtlq_pkg::ST_DRAIN) begin
        backlog_q <= drained;
      end else if (div_start) begin
        backlog_q <= total;
      end
      if (state_q == dtlq_pkg::ST_DONE && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_hs) begin
      now_q     <= s_now;
      size_q    <= s_axis_tdata[51:32];
      from_q    <= s_axis_tdata[52];
      elapsed_q <= (s_now >= last_q) ? s_now - last_q : '0;
    end
    if (state_q == dtlq_pkg::ST_MUL) begin
      drain_q <= product;
    end
    if (state_q == dtlq_pkg::ST_CHECK) begin
      acc_q    <= admit;
      base_q   <= {1'b0, now_q} + {9'b0, cfg.prop};
      depart_q <= '0;
    end
    if (state_q == dtlq_pkg::ST_DIV && div_stat.done) begin
      depart_q <= {1'b0, base_q} + {2'b0, quotient};
    end
    if (state_q == dtlq_pkg::ST_DONE && out_free) begin
      m_data_q <= {4'b0, acc_q & ~from_q, depart_q, acc_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  a_backlog_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !backlog_q[dtlq_pkg::BacklogW-1])
    else $error("backlog reached 2^32");

  a_div_in_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> (state_q == dtlq_pkg::ST_DIV))
    else $error("divider busy outside divide state");

  a_admit_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> (div_stat.busy && state_q == dtlq_pkg::ST_DIV))
    else $error("admitted packet did not start divide");

  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_data_q[0]) |-> (m_data_q[dtlq_pkg::OutDataW-1:1] == '0))
    else $error("dropped packet carries nonzero fields");

endmodule

`default_nettype wire

>>> hdl/dtlq_cfg_regs.sv
`default_nettype none

module dtlq_cfg_regs (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [dtlq_pkg::AddrW-1:0]           paddr,
  input  wire logic [dtlq_pkg::ApbDataW-1:0]        pwdata,
  output logic      [dtlq_pkg::ApbDataW-1:0]        prdata,
  output logic                                      pready,
  output dtlq_pkg::cfg_t                            cfg_o
);

  logic [dtlq_pkg::CapW-1:0]  cap_q;
  logic [dtlq_pkg::PropW-1:0] prop_q;
  logic [dtlq_pkg::BufW-1:0]  buf_q;
  logic                       wr_en;
  logic [1:0]                 reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= dtlq_pkg::CapReset;
      prop_q <= dtlq_pkg::PropReset;
      buf_q  <= dtlq_pkg::BufReset;
    end else if (wr_en) begin
      case (reg_idx)
        dtlq_pkg::RegCapacity:    cap_q  <= pwdata[dtlq_pkg::CapW-1:0];
        dtlq_pkg::RegPropagation: prop_q <= pwdata[dtlq_pkg::PropW-1:0];
        dtlq_pkg::RegBuffer:      buf_q  <= pwdata[dtlq_pkg::BufW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      dtlq_pkg::RegCapacity:    prdata = {16'b0, cap_q};
      dtlq_pkg::RegPropagation: prdata = {8'b0, prop_q};
      dtlq_pkg::RegBuffer:      prdata = buf_q;
      default:                  prdata = '0;
    endcase
  end

  assign cfg_o.cap_eff  = (cap_q == '0) ? dtlq_pkg::CapW'(1) : cap_q;
  assign cfg_o.prop     = prop_q;
  assign cfg_o.buf_bits = buf_q;

endmodule

`default_nettype wire

>>> hdl/dtlq_divider.sv
`default_nettype none

module dtlq_divider (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [dtlq_pkg::QuoW-1:0]     dividend_i,
  input  wire logic [dtlq_pkg::CapW-1:0]     divisor_i,
  output logic      [dtlq_pkg::QuoW-1:0]     quotient_o,
  output dtlq_pkg::div_stat_t                stat_o
);

  localparam logic [dtlq_pkg::StepCntW-1:0] LastStep =
    dtlq_pkg::StepCntW'(dtlq_pkg::QuoW - 1);

  logic [dtlq_pkg::CapW-1:0]     rem_q, rem_d;
  logic [dtlq_pkg::CapW-1:0]     div_q;
  logic [dtlq_pkg::QuoW-1:0]     quo_q;
  logic [dtlq_pkg::StepCntW-1:0] cnt_q;
  logic                          busy_q, done_q;
  logic [dtlq_pkg::CapW:0]       trial;
  logic                          fits;

  assign trial = {rem_q, quo_q[dtlq_pkg::QuoW-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    if (fits) begin
      rem_d = dtlq_pkg::CapW'(trial - {1'b0, div_q});
    end else begin
      rem_d = trial[dtlq_pkg::CapW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      div_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[dtlq_pkg::QuoW-2:0], fits};
    end
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

`default_nettype wire

>>> tb/sv/drop_tail_link_queue_timer_checker.sv
module drop_tail_link_queue_timer_checker
  import dtlq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  // [31:0] arrival_time, [51:32] packet_bits, [52] from_end, [55:53] zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [0] accepted, [34:1] depart_time, [35] to_end, [39:36] zero
  input  logic [OutDataW-1:0] m_axis_tdata,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [ApbDataW-1:0] pwdata,
  input  logic                pready,
  output int unsigned         fail_cnt_o,
  output int unsigned         pending_o,
  output int unsigned         admitted_o,
  output int unsigned         dropped_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic               accepted;
    logic [DepartW-1:0] depart_time;
    logic               to_end;
  } departure_t;

  logic [CapW-1:0]     cap_reg;
  logic [PropW-1:0]    prop_reg;
  logic [BufW-1:0]     buffer_reg;
  logic [BacklogW-1:0] link_backlog;
  logic [TimeW-1:0]    prev_arrival;
  departure_t          departures_q[$];
  int unsigned         fail_cnt;
  int unsigned         admitted_cnt;
  int unsigned         dropped_cnt;

  function automatic departure_t predict_departure(input logic [TimeW-1:0] now,
                                                   input logic [SizeW-1:0] size,
                                                   input logic from_end);
    logic [CapW-1:0]     cap;
    logic [TimeW-1:0]    elapsed;
    logic [DrainW-1:0]   drain;
    logic [BacklogW-1:0] total;
    departure_t          res;
    cap = (cap_reg == '0) ? CapW'(1) : cap_reg;
    elapsed = (now >= prev_arrival) ? now - prev_arrival : '0;
    drain = DrainW'(elapsed) * DrainW'(cap);
    link_backlog = (drain >= DrainW'(link_backlog)) ? '0 : link_backlog - BacklogW'(drain);
    total = link_backlog + BacklogW'(size);
    res = '0;
    if (total < BacklogW'(buffer_reg)) begin
      res.accepted = 1'b1;
      res.depart_time = DepartW'(now) + DepartW'(prop_reg) + DepartW'(total / BacklogW'(cap));
      res.to_end = ~from_end;
      link_backlog = total;
    end
    prev_arrival = now;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    departure_t want;
    departure_t got;
    if (!rst_ni) begin
      cap_reg = CapReset;
      prop_reg = PropReset;
      buffer_reg = BufReset;
      link_backlog = '0;
      prev_arrival = '0;
      departures_q.delete();
      fail_cnt = 0;
      admitted_cnt = 0;
      dropped_cnt = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[AddrW-1:2])
          RegCapacity:    cap_reg = pwdata[CapW-1:0];
          RegPropagation: prop_reg = pwdata[PropW-1:0];
          RegBuffer:      buffer_reg = pwdata[BufW-1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.accepted = m_axis_tdata[0];
        got.depart_time = m_axis_tdata[DepartW:1];
        got.to_end = m_axis_tdata[DepartW+1];
        if (departures_q.size() == 0) begin
          $display("%0t: unexpected result, nothing expected,", $time,
                   " got accepted=%0d depart_time=%0d to_end=%0d",
                   got.accepted, got.depart_time, got.to_end);
          fail_cnt++;
        end else begin
          want = departures_q.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch, expected", $time,
                     " accepted=%0d depart_time=%0d to_end=%0d,",
                     want.accepted, want.depart_time, want.to_end,
                     " got accepted=%0d depart_time=%0d to_end=%0d",
                     got.accepted, got.depart_time, got.to_end);
            fail_cnt++;
          end
          if (want.accepted) admitted_cnt++;
          else dropped_cnt++;
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        departures_q.push_back(predict_departure(s_axis_tdata[TimeW-1:0],
                                                 s_axis_tdata[TimeW+SizeW-1:TimeW],
                                                 s_axis_tdata[TimeW+SizeW]));
    end
    fail_cnt_o <= fail_cnt;
    pending_o <= departures_q.size();
    admitted_o <= admitted_cnt;
    dropped_o <= dropped_cnt;
  end

endmodule

>>> tb/sv/tb_drop_tail_link_queue_timer_core.sv
module tb_drop_tail_link_queue_timer_core;
  timeunit 1ns;
  timeprecision 1ps;
  import dtlq_pkg::*;

  localparam int unsigned ResetCycles  = 7;
  localparam int unsigned DrainSlack   = 40;
  localparam int unsigned RxHoldCycles = 300;
  localparam int unsigned Phases       = 8;
  localparam int unsigned PhaseItems   = 125;
  localparam int unsigned HoldPhase    = 6;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [AddrW-1:0]    paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned admitted;
  int unsigned dropped;

  int unsigned tx_idle_pct = 28;
  int unsigned rx_idle_pct = 87;
  int unsigned hold_asked = 0;
  int unsigned hold_taken = 0;
  int unsigned hold_left = 0;
  int unsigned arrivals_sent = 0;
  int unsigned reg_writes = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  drop_tail_link_queue_timer_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  drop_tail_link_queue_timer_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .fail_cnt_o    (fail_cnt),
    .pending_o     (pending),
    .admitted_o    (admitted),
    .dropped_o     (dropped)
  );

  // hold off for a long stretch on request, else stall at random
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_taken != hold_asked) begin
      hold_taken <= hold_asked;
      hold_left <= RxHoldCycles;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  task automatic offer_arrival(input logic [TimeW-1:0] at, input logic [SizeW-1:0] bits,
                               input logic from_end);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {3'b000, from_end, bits, at};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    arrivals_sent++;
  endtask

  task automatic settle_link(input int unsigned extra);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [ApbDataW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    reg_writes++;
  endtask

  initial begin : stimulus
    logic [CapW-1:0]  cap;
    logic [PropW-1:0] prop;
    logic [BufW-1:0]  buffer;
    logic [TimeW-1:0] now_ticks;
    logic [TimeW-1:0] at;
    logic [SizeW-1:0] bits;
    logic             from_end;
    int unsigned      size_max;
    int unsigned      gap_max;
    int unsigned      roll;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero buffer after reset: everything drops
    offer_arrival(32'd0, 20'd0, 1'b0);
    offer_arrival(32'd100, '1, 1'b1);
    settle_link(DrainSlack);

    // zero capacity acts as one bit per tick
    write_reg(RegCapacity, 32'd0);
    write_reg(RegPropagation, 32'hFF_FFFF);
    write_reg(RegBuffer, 32'hFFFF_FFFF);
    offer_arrival(32'd200, 20'd0, 1'b0);
    offer_arrival(32'd200, '1, 1'b1);
    offer_arrival(32'd150, 20'd5, 1'b0);
    offer_arrival('1, '1, 1'b0);
    offer_arrival('1, '1, 1'b1);
    settle_link(DrainSlack);

    // time going backwards, then the admission boundary
    write_reg(RegCapacity, 32'hFFFF);
    write_reg(RegPropagation, 32'd0);
    write_reg(RegBuffer, 32'd1000);
    offer_arrival(32'd10, 20'd999, 1'b0);
    offer_arrival(32'd1000, 20'd999, 1'b1);
    offer_arrival(32'd1000, 20'd0, 1'b0);
    offer_arrival(32'd1000, 20'd1, 1'b1);
    offer_arrival(32'd5000, 20'd500, 1'b0);
    now_ticks = 32'd5000;

    for (int unsigned phase = 0; phase < Phases; phase++) begin
      settle_link(DrainSlack);
      case (phase % 4)
        0: cap = 16'd1;
        1: cap = 16'hFFFF;
        2: cap = 16'd0;
        default: cap = CapW'($urandom_range(2, 4096));
      endcase
      prop = (phase == 2) ? 24'hFF_FFFF : (phase == 5) ? 24'd0 : PropW'($urandom);
      buffer = (phase == 3) ? 32'hFFFF_FFFF : BufW'($urandom_range(32'h100, 32'h40_0000));
      write_reg(RegCapacity, ApbDataW'(cap));
      write_reg(RegPropagation, ApbDataW'(prop));
      write_reg(RegBuffer, ApbDataW'(buffer));

      size_max = buffer / 4;
      if (size_max > 20'hF_FFFF) size_max = 20'hF_FFFF;
      if (size_max < 16) size_max = 16;
      gap_max = size_max / ((cap == '0) ? 1 : cap) + 1;

      if (phase < 3) begin
        tx_idle_pct = 28;
        rx_idle_pct = 87;
      end else if (phase < HoldPhase) begin
        tx_idle_pct = 87;
        rx_idle_pct = 28;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end

      for (int unsigned n = 0; n < PhaseItems; n++) begin
        if (phase == HoldPhase && n == 1) hold_asked++;
        roll = $urandom_range(0, 99);
        from_end = 1'($urandom_range(0, 1));
        if (roll < 8) begin
          at = $urandom;
          bits = SizeW'($urandom);
        end else if (roll < 13) begin
          at = now_ticks - TimeW'($urandom_range(0, 1000));
          bits = SizeW'($urandom_range(0, size_max));
        end else begin
          at = (roll < 23) ? now_ticks : now_ticks + TimeW'($urandom_range(0, gap_max));
          bits = (roll < 27) ? '0 : (roll < 30) ? '1 : SizeW'($urandom_range(0, size_max));
        end
        now_ticks = at;
        offer_arrival(at, bits, from_end);
      end
    end

    settle_link(DrainSlack);
    $display("covered %0d arrivals and %0d register writes over %0d link settings",
             arrivals_sent, reg_writes, Phases + 3);
    $display("packets admitted: %0d, dropped: %0d", admitted, dropped);
    if (fail_cnt == 0) begin
      $display("** drop_tail_link_queue_timer_core: PASSED **");
    end else begin
      $display("** drop_tail_link_queue_timer_core: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("** drop_tail_link_queue_timer_core: FAILED **");
    $finish;
  end

endmodule

>>> files.f
hdl/dtlq_pkg.sv
hdl/dtlq_cfg_regs.sv
hdl/dtlq_divider.sv
hdl/drop_tail_link_queue_timer_core.sv
tb/sv/drop_tail_link_queue_timer_checker.sv
tb/sv/tb_drop_tail_link_queue_timer_core.sv
